@@ hw/rtl/crw_pkg.sv @@
// ----------------------------------------------------------------------------
// crw_pkg: shared types and constants of the cuckoo random walk placer
// Holds command and status codes, hash constants and the control structs
// passed between the placer and the mixing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package crw_pkg;

   // Command codes of an input item.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Status codes of a result item.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FAIL = 2'd2
   } status_type;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_SEED     = 2'd0;
   localparam logic [1:0] REG_BCOUNT   = 2'd1;
   localparam logic [1:0] REG_HCOUNT   = 2'd2;
   localparam logic [1:0] REG_MAXSTEPS = 2'd3;

   // Reset values of the registers.
   localparam logic [10:0] BCOUNT_RST   = 11'd1024;
   localparam logic [2:0]  HCOUNT_RST   = 3'd3;
   localparam logic [15:0] MAXSTEPS_RST = 16'd10000;

   // Hash constants.
   localparam logic [63:0] K_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] K_MIX1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] K_MIX2   = 64'h94d049bb133111eb;
   localparam logic [63:0] K_ORD    = 64'hd6e8feb86659fd93;
   localparam logic [63:0] K_WALK   = 64'h0000000066616365;

   // Golden ratio times (j+1), modulo 2^64, for candidate j.
   localparam logic [63:0] GOLD_MUL [4] = '{
      64'h9e3779b97f4a7c15,
      64'h3c6ef372fe94f82a,
      64'hdaa66d2c7ddf743f,
      64'h78dde6e5fd29f054
   };

   // Placer sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_CAND_HASH,
      ST_CAND_HWAIT,
      ST_CAND_MWAIT,
      ST_CAND_CHK,
      ST_WALK_HASH,
      ST_WALK_HWAIT,
      ST_WALK_MWAIT,
      ST_DONE
   } state_type;

   // Mixing unit sequencer states.
   typedef enum logic [3:0] {
      MX_IDLE,
      MX_ORD_LO,
      MX_ORD_HI,
      MX_PREP1,
      MX_M1_LL,
      MX_M1_LH,
      MX_M1_HL,
      MX_PREP2,
      MX_M2_LL,
      MX_M2_LH,
      MX_M2_HL,
      MX_FIN
   } mix_state_type;

   // Request to the mixing unit.
   typedef struct packed {
      logic        start;
      logic        use_ord;
      logic [63:0] key;
      logic [31:0] ord;
   } mix_req_type;

   // Answer of the mixing unit.
   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } mix_rsp_type;

endpackage

`default_nettype wire

@@ hw/rtl/crw_ram.sv @@
// ----------------------------------------------------------------------------
// crw_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module crw_ram #(
   parameter int unsigned WIDTH = 33,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/crw_mix.sv @@
// ----------------------------------------------------------------------------
// crw_mix: multi-cycle splitmix64 finalizer
// Optionally forms key ^ ord*K_ORD first, then applies the finalizer. All
// 64-bit products are built from 32x32 partial products on one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module crw_mix
   import crw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mix_req_type req,
   output mix_rsp_type      rsp
);

   mix_state_type state_ff, state_in;
   logic [63:0]   key_ff, key_in;
   logic [63:0]   val_ff, val_in;
   logic [63:0]   acc_ff, acc_in;
   logic [63:0]   res_ff, res_in;
   logic          done_ff, done_in;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   prod;
   logic [63:0]   pre;
   logic [63:0]   mid;

   // Shared 32x32 multiplier.
   assign prod = {32'd0, mul_a} * {32'd0, mul_b};
   assign pre  = (key_ff ^ acc_ff) + K_GOLDEN;
   assign mid  = acc_ff ^ (acc_ff >> 27);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      val_in   = val_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      mul_a    = val_ff[31:0];
      mul_b    = K_MIX1[31:0];
      unique case (state_ff)
         MX_IDLE: begin
            if (req.start) begin
               key_in   = req.key;
               val_in   = {32'd0, req.ord};
               acc_in   = '0;
               state_in = req.use_ord ? MX_ORD_LO : MX_PREP1;
            end
         end
         MX_ORD_LO: begin
            mul_b    = K_ORD[31:0];
            acc_in   = prod;
            state_in = MX_ORD_HI;
         end
         MX_ORD_HI: begin
            mul_b    = K_ORD[63:32];
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = MX_PREP1;
         end
         MX_PREP1: begin
            val_in   = pre ^ (pre >> 30);
            acc_in   = '0;
            state_in = MX_M1_LL;
         end
         MX_M1_LL: begin
            acc_in   = prod;
            state_in = MX_M1_LH;
         end
         MX_M1_LH: begin
            mul_b    = K_MIX1[63:32];
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = MX_M1_HL;
         end
         MX_M1_HL: begin
            mul_a    = val_ff[63:32];
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = MX_PREP2;
         end
         MX_PREP2: begin
            val_in   = mid;
            acc_in   = '0;
            state_in = MX_M2_LL;
         end
         MX_M2_LL: begin
            mul_b    = K_MIX2[31:0];
            acc_in   = prod;
            state_in = MX_M2_LH;
         end
         MX_M2_LH: begin
            mul_b    = K_MIX2[63:32];
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = MX_M2_HL;
         end
         MX_M2_HL: begin
            mul_a    = val_ff[63:32];
            mul_b    = K_MIX2[31:0];
            acc_in   = acc_ff + {prod[31:0], 32'd0};
            state_in = MX_FIN;
         end
         MX_FIN: begin
            res_in   = acc_ff ^ (acc_ff >> 31);
            done_in  = 1'b1;
            state_in = MX_IDLE;
         end
         default: state_in = MX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MX_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      key_ff <= key_in;
      val_ff <= val_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

`ifndef SYNTH
   // A finished hash leaves the unit idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == MX_IDLE)
      else $error("mix done while busy");
   // The final state always raises done in the next cycle.
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == MX_FIN |=> done_ff)
      else $error("mix finished without done");
   // A new start is only seen by an idle unit.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> state_ff == MX_IDLE)
      else $error("mix started while busy");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/crw_mod.sv @@
// ----------------------------------------------------------------------------
// crw_mod: bit-serial remainder unit
// Computes a 64-bit dividend modulo a narrow divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crw_mod #(
   parameter int unsigned DW = 11
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [63:0]   dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      rem
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [63:0]   dvd_ff, dvd_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   trial;

   assign trial = {rem_ff, dvd_ff[63]};

   // One restoring step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = DW'(trial);
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

`ifndef SYNTH
   // The remainder is below the divisor when reported.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_ff && dsr_ff != '0 |-> rem_ff < dsr_ff)
      else $error("remainder out of range");
   // Done only follows the last step.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("remainder done without work");
   // A start never arrives during work.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder started while busy");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cuckoo_random_walk_placer_unit.sv @@
// ----------------------------------------------------------------------------
// cuckoo_random_walk_placer_unit: cuckoo table with random-walk insertion
//
// Items arrive on the req_ stream: insert an ordinal, read a bucket, clear the
// table, or do nothing. Each item yields exactly one result item on the rsp_
// stream with a status, an occupied flag and an ordinal. Registers are written
// on the csr_ port; the user must write them only while the block is idle,
// which the block itself does not enforce. The table sits in one RAM of
// MAX_BUCKETS entries. A read takes the registered RAM data in ST_READ_WAIT
// and answers from ST_DONE. Each candidate scanned takes a hash on the shared
// 32x32 multiplier, a bit-serial remainder and the RAM check; each eviction
// takes a walk hash and the remainder. A clear, and reset, sweep every RAM
// entry, one a cycle, and no item is accepted during the sweep; the clear
// then answers. The block takes a new item while a finished result still
// waits in the output register; if the receiver stalls, the next result
// holds in the sequencer until the output register frees, and no item is
// taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_random_walk_placer_unit
   import crw_pkg::*;
#(
   parameter int unsigned MAX_BUCKETS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[1:0], ordinal[33:2], bucket_index[43:34], zero[47:44]
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], occupied[2], occupant_ordinal[34:3], zero[39:35]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   localparam int unsigned AW  = $clog2(MAX_BUCKETS);
   localparam int unsigned CW  = (AW + 1 > 11) ? AW + 1 : 11;
   localparam int unsigned XW  = (AW > 10) ? AW : 10;
   localparam logic [XW:0] IDX_END = (XW + 1)'(MAX_BUCKETS);

   // Input fields.
   cmd_type     in_cmd;
   logic [31:0] in_ord;
   logic [9:0]  in_idx;
   logic [XW-1:0] idx_ext;
   logic        in_range;
   logic        req_acc;

   assign in_cmd   = cmd_type'(req_tdata[1:0]);
   assign in_ord   = req_tdata[33:2];
   assign in_idx   = req_tdata[43:34];
   assign idx_ext  = XW'(in_idx);
   assign in_range = {1'b0, idx_ext} < IDX_END;

   // Registers.
   state_type       state_ff, state_in;
   logic [63:0]     seed_ff;
   logic [10:0]     bcnt_ff;
   logic [2:0]      hcnt_ff;
   logic [15:0]     mws_ff;
   logic [63:0]     walk_ff, walk_in;
   logic [31:0]     cur_ff, cur_in;
   logic [1:0]      j_ff, j_in;
   logic [15:0]     step_ff, step_in;
   logic [AW-1:0]   cand_ff [4];
   logic [AW-1:0]   cand_in [4];
   logic [31:0]     citem_ff [4];
   logic [31:0]     citem_in [4];
   logic [AW-1:0]   clr_ff, clr_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic            rng_ff, rng_in;
   status_type      res_st_ff, res_st_in;
   logic            res_occ_ff, res_occ_in;
   logic [31:0]     res_val_ff, res_val_in;
   logic            rsp_v_ff, rsp_v_in;
   logic [34:0]     rsp_d_ff, rsp_d_in;

   // Effective register values.
   logic [CW-1:0]   bc_ext, nb;
   logic [2:0]      nh;
   logic [15:0]     lim;

   assign bc_ext = CW'(bcnt_ff);
   assign nb = (bc_ext < CW'(2)) ? CW'(2) :
               (bc_ext > CW'(MAX_BUCKETS)) ? CW'(MAX_BUCKETS) : bc_ext;
   assign nh  = (hcnt_ff == 3'd0) ? 3'd1 : (hcnt_ff > 3'd4) ? 3'd4 : hcnt_ff;
   assign lim = (mws_ff == 16'd0) ? 16'd1 : mws_ff;

   // Table RAM: bit 32 is the full flag.
   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [32:0]     ram_wdata, ram_rdata;

   crw_ram #(.WIDTH(33), .DEPTH(MAX_BUCKETS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Hash and remainder units.
   mix_req_type     mix_req;
   mix_rsp_type     mix_rsp;
   logic            mod_start, mod_done;
   logic [CW-1:0]   mod_dsr, mod_rem;

   crw_mix u_mix (
      .clock (clock),
      .reset (reset),
      .req   (mix_req),
      .rsp   (mix_rsp)
   );

   crw_mod #(.DW(CW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (mix_rsp.result),
      .divisor  (mod_dsr),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   logic            rsp_free;
   logic [1:0]      sel;
   logic [16:0]     step_nx;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_v_ff || rsp_tready;
   assign sel      = mod_rem[1:0];
   assign step_nx  = {1'b0, step_ff} + 17'd1;

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in   = state_ff;
      walk_in    = walk_ff;
      cur_in     = cur_ff;
      j_in       = j_ff;
      step_in    = step_ff;
      cand_in    = cand_ff;
      citem_in   = citem_ff;
      clr_in     = clr_ff;
      clr_rsp_in = clr_rsp_ff;
      rng_in     = rng_ff;
      res_st_in  = res_st_ff;
      res_occ_in = res_occ_ff;
      res_val_in = res_val_ff;
      rsp_v_in   = rsp_v_ff && !rsp_tready;
      rsp_d_in   = rsp_d_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = clr_ff;
      ram_wdata  = '0;
      ram_raddr  = AW'(idx_ext);
      mix_req    = '0;
      mod_start  = 1'b0;
      mod_dsr    = nb;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_BUCKETS - 1)) begin
               if (clr_rsp_ff) begin
                  res_st_in  = STATUS_OK;
                  res_occ_in = 1'b0;
                  res_val_in = '0;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (in_cmd)
                  CMD_INSERT: begin
                     cur_in   = in_ord;
                     j_in     = '0;
                     step_in  = '0;
                     state_in = ST_CAND_HASH;
                  end
                  CMD_READ: begin
                     rng_in   = in_range;
                     state_in = ST_READ_WAIT;
                  end
                  CMD_CLEAR: begin
                     walk_in    = seed_ff ^ K_WALK;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     res_st_in  = STATUS_OK;
                     res_occ_in = 1'b0;
                     res_val_in = '0;
                     state_in   = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_st_in  = STATUS_OK;
            res_occ_in = rng_ff && ram_rdata[32];
            res_val_in = (rng_ff && ram_rdata[32]) ? ram_rdata[31:0] : 32'd0;
            state_in   = ST_DONE;
         end
         ST_CAND_HASH: begin
            mix_req.start   = 1'b1;
            mix_req.use_ord = 1'b1;
            mix_req.key     = seed_ff ^ GOLD_MUL[j_ff];
            mix_req.ord     = cur_ff;
            state_in        = ST_CAND_HWAIT;
         end
         ST_CAND_HWAIT: begin
            if (mix_rsp.done) begin
               mod_start = 1'b1;
               state_in  = ST_CAND_MWAIT;
            end
         end
         ST_CAND_MWAIT: begin
            ram_raddr = mod_rem[AW-1:0];
            if (mod_done) begin
               cand_in[j_ff] = mod_rem[AW-1:0];
               state_in      = ST_CAND_CHK;
            end
         end
         ST_CAND_CHK: begin
            citem_in[j_ff] = ram_rdata[31:0];
            if (ram_rdata[32] && ram_rdata[31:0] == cur_ff) begin
               res_st_in  = STATUS_DUP;
               res_occ_in = 1'b1;
               res_val_in = cur_ff;
               state_in   = ST_DONE;
            end else if (!ram_rdata[32]) begin
               ram_we     = 1'b1;
               ram_waddr  = cand_ff[j_ff];
               ram_wdata  = {1'b1, cur_ff};
               res_st_in  = STATUS_OK;
               res_occ_in = 1'b0;
               res_val_in = '0;
               state_in   = ST_DONE;
            end else if ({1'b0, j_ff} == nh - 3'd1) begin
               state_in = ST_WALK_HASH;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_CAND_HASH;
            end
         end
         ST_WALK_HASH: begin
            mix_req.start   = 1'b1;
            mix_req.use_ord = 1'b0;
            mix_req.key     = walk_ff;
            state_in        = ST_WALK_HWAIT;
         end
         ST_WALK_HWAIT: begin
            mod_dsr = CW'(nh);
            if (mix_rsp.done) begin
               walk_in   = mix_rsp.result;
               mod_start = 1'b1;
               state_in  = ST_WALK_MWAIT;
            end
         end
         ST_WALK_MWAIT: begin
            if (mod_done) begin
               // Evict the occupant of the chosen candidate.
               ram_we    = 1'b1;
               ram_waddr = cand_ff[sel];
               ram_wdata = {1'b1, cur_ff};
               cur_in    = citem_ff[sel];
               if (step_nx == {1'b0, lim}) begin
                  res_st_in  = STATUS_FAIL;
                  res_occ_in = 1'b1;
                  res_val_in = citem_ff[sel];
                  state_in   = ST_DONE;
               end else begin
                  step_in  = step_nx[15:0];
                  j_in     = '0;
                  state_in = ST_CAND_HASH;
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {res_val_ff, res_occ_ff, res_st_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_v_ff   <= 1'b0;
         walk_ff    <= K_WALK;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_v_ff   <= rsp_v_in;
         walk_ff    <= walk_in;
      end
      cur_ff     <= cur_in;
      j_ff       <= j_in;
      step_ff    <= step_in;
      cand_ff    <= cand_in;
      citem_ff   <= citem_in;
      rng_ff     <= rng_in;
      res_st_ff  <= res_st_in;
      res_occ_ff <= res_occ_in;
      res_val_ff <= res_val_in;
      rsp_d_ff   <= rsp_d_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         bcnt_ff <= BCOUNT_RST;
         hcnt_ff <= HCOUNT_RST;
         mws_ff  <= MAXSTEPS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_SEED:     seed_ff <= csr_wdata;
            REG_BCOUNT:   bcnt_ff <= csr_wdata[10:0];
            REG_HCOUNT:   hcnt_ff <= csr_wdata[2:0];
            REG_MAXSTEPS: mws_ff  <= csr_wdata[15:0];
            default:      seed_ff <= seed_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {5'd0, rsp_d_ff};

`ifndef SYNTH
   // The table is never written while waiting for an item.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ram_we)
      else $error("table written while idle");
   // During an insert the walk counter stays below the step limit.
   a_step_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && state_ff != ST_CLEAR && state_ff != ST_DONE &&
      state_ff != ST_READ_WAIT |-> step_ff < lim)
      else $error("walk step count past limit");
   // Duplicate and failure results always report an ordinal.
   a_occ_status: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && (rsp_d_ff[1:0] == STATUS_DUP || rsp_d_ff[1:0] == STATUS_FAIL)
      |-> rsp_d_ff[2])
      else $error("error result without ordinal");
   // Reset starts the clearing sweep.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> state_ff == ST_CLEAR)
      else $error("reset did not start the sweep");
`endif

endmodule

`default_nettype wire

@@ tb/cuckoo_random_walk_placer_checker.sv @@
// ----------------------------------------------------------------------------
// cuckoo_random_walk_placer_checker: result checker of the placer
// Watches the req_, rsp_ and csr_ ports of the placer and keeps its own copy
// of the bucket table, the eviction walk state and the registers. Every
// accepted input item is predicted into an expected result item, and every
// accepted result item is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_random_walk_placer_checker
   import crw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // cmd[1:0], ordinal[33:2], bucket_index[43:34], zero[47:44]
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], occupied[2], occupant_ordinal[34:3], zero[39:35]
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata,
   output int               pending,
   output int               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = 1024;

   typedef struct packed {
      status_type  status;
      logic        occupied;
      logic [31:0] ordinal;
   } placer_result_type;

   // Shadow copy of the block state.
   logic [63:0] seed_q;
   logic [10:0] bcount_q;
   logic [2:0]  hcount_q;
   logic [15:0] maxsteps_q;
   logic        bucket_full [TABLE_SIZE];
   logic [31:0] bucket_ord  [TABLE_SIZE];
   logic [63:0] evict_walk_q;

   placer_result_type awaited_results [$];
   int                result_count;

   initial fail_count = 0;
   initial pending = 0;

   // The splitmix64 finalizer, applied after adding the golden constant.
   function automatic logic [63:0] splitmix(input logic [63:0] v);
      logic [63:0] m;
      m = v + K_GOLDEN;
      m = (m ^ (m >> 30)) * K_MIX1;
      m = (m ^ (m >> 27)) * K_MIX2;
      return m ^ (m >> 31);
   endfunction

   // Candidate bucket j of an ordinal under the current seed.
   function automatic int unsigned candidate_bucket(input logic [31:0] ord,
                                                    input logic [63:0] j,
                                                    input logic [63:0] nb);
      logic [63:0] h;
      h = splitmix(seed_q ^ (K_GOLDEN * (j + 64'd1)) ^ ({32'd0, ord} * K_ORD));
      return int'(h % nb);
   endfunction

   function automatic void empty_table();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         bucket_full[i] = 1'b0;
         bucket_ord[i]  = '0;
      end
      evict_walk_q = seed_q ^ K_WALK;
   endfunction

   // Random-walk insert; updates the shadow table and returns the result.
   function automatic placer_result_type place_ordinal(input logic [31:0] ord);
      placer_result_type res;
      logic [63:0] nb, nh, lim, step, j;
      logic [31:0] carried, evicted;
      logic        placed, dup, free;
      int unsigned b, fb;
      nb = (bcount_q < 11'd2) ? 64'd2 :
           (bcount_q > 11'd1024) ? 64'd1024 : {53'd0, bcount_q};
      nh = (hcount_q < 3'd1) ? 64'd1 : (hcount_q > 3'd4) ? 64'd4 : {61'd0, hcount_q};
      lim = (maxsteps_q == 16'd0) ? 64'd1 : {48'd0, maxsteps_q};
      carried = ord;
      placed = 1'b0;
      dup = 1'b0;
      fb = 0;
      res = '0;
      res.status = STATUS_OK;
      for (step = 0; step < lim && !placed && !dup; step++) begin
         free = 1'b0;
         // Scan candidates up to the first empty one or a duplicate.
         for (j = 0; j < nh && !free && !dup; j++) begin
            b = candidate_bucket(carried, j, nb);
            if (bucket_full[b] && bucket_ord[b] == carried)
               dup = 1'b1;
            else if (!bucket_full[b]) begin
               free = 1'b1;
               fb = b;
            end
         end
         if (!dup && free) begin
            bucket_full[fb] = 1'b1;
            bucket_ord[fb]  = carried;
            placed = 1'b1;
         end else if (!dup) begin
            // All candidates full: evict the occupant the walk picks.
            evict_walk_q = splitmix(evict_walk_q);
            b = candidate_bucket(carried, evict_walk_q % nh, nb);
            evicted = bucket_ord[b];
            bucket_ord[b]  = carried;
            bucket_full[b] = 1'b1;
            carried = evicted;
         end
      end
      if (dup) begin
         res.status = STATUS_DUP;
         res.occupied = 1'b1;
         res.ordinal = carried;
      end else if (!placed) begin
         res.status = STATUS_FAIL;
         res.occupied = 1'b1;
         res.ordinal = carried;
      end
      return res;
   endfunction

   function automatic placer_result_type predict_result(input logic [47:0] item);
      placer_result_type res;
      cmd_type     cmd;
      logic [31:0] ord;
      logic [9:0]  idx;
      cmd = cmd_type'(item[1:0]);
      ord = item[33:2];
      idx = item[43:34];
      res = '0;
      res.status = STATUS_OK;
      case (cmd)
         CMD_INSERT: res = place_ordinal(ord);
         CMD_READ: begin
            if (bucket_full[idx]) begin
               res.occupied = 1'b1;
               res.ordinal = bucket_ord[idx];
            end
         end
         CMD_CLEAR: empty_table();
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $realtime, result_count, what);
      fail_count++;
   endtask

   // Compare results first: a result never belongs to an item taken at the
   // same edge.
   always @(posedge clock) begin
      placer_result_type want;
      if (reset) begin
         seed_q = '0;
         bcount_q = BCOUNT_RST;
         hcount_q = HCOUNT_RST;
         maxsteps_q = MAXSTEPS_RST;
         empty_table();
         awaited_results.delete();
         result_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0)
               report_mismatch("result item with nothing expected");
            else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tdata[1:0], want.status));
               if (rsp_tdata[2] != want.occupied)
                  report_mismatch($sformatf("occupied %0b, expected %0b",
                                            rsp_tdata[2], want.occupied));
               if (rsp_tdata[34:3] != want.ordinal)
                  report_mismatch($sformatf("ordinal %h, expected %h",
                                            rsp_tdata[34:3], want.ordinal));
            end
            result_count++;
         end
         if (req_tvalid && req_tready)
            awaited_results.insert(awaited_results.size(), predict_result(req_tdata));
         if (csr_we) begin
            case (csr_addr)
               REG_SEED:     seed_q = csr_wdata;
               REG_BCOUNT:   bcount_q = csr_wdata[10:0];
               REG_HCOUNT:   hcount_q = csr_wdata[2:0];
               REG_MAXSTEPS: maxsteps_q = csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      pending = awaited_results.size();
   end

endmodule

`default_nettype wire

@@ tb/tb_cuckoo_random_walk_placer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_cuckoo_random_walk_placer_unit: testbench of the cuckoo placer
// Drives directed and random insert, read, clear and no-op items through
// several register settings, with random idling on both streams, and leaves
// all checking to the checker module beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cuckoo_random_walk_placer_unit;
   import crw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int HOLD_AT     = 350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [63:0] csr_wdata = '0;
   int          pending;
   int          fail_count;

   int          gap_max = 4;
   int          eff_buckets = 1024;
   int          cycles = 0;
   int          results_seen = 0;
   int          stall_left = 0;
   logic [31:0] ord_pool [$];

   cuckoo_random_walk_placer_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   cuckoo_random_walk_placer_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   always #5 clock = ~clock;

   // Run watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cuckoo_random_walk_placer_unit: mismatch");
         $finish;
      end
   end

   // Result receiver: random stall after each item, and one long hold-off
   // so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            stall_left = (results_seen == HOLD_AT) ? LONG_HOLD
                                                   : $urandom_range(0, gap_max);
         end else if (stall_left > 0)
            stall_left--;
         rsp_tready <= (stall_left == 0);
      end
   end

   // Offer one item after a random gap and hold it until accepted.
   task automatic send_item(input cmd_type cmd, input logic [31:0] ord,
                            input logic [9:0] idx);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, idx, ord, cmd};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_registers(input logic [63:0] seed, input logic [10:0] bcount,
                                input logic [2:0] hcount, input logic [15:0] maxsteps);
      logic [63:0] values [4];
      values = '{seed, {53'd0, bcount}, {61'd0, hcount}, {48'd0, maxsteps}};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_addr <= 2'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      eff_buckets = (bcount < 2) ? 2 : (bcount > 1024) ? 1024 : int'(bcount);
   endtask

   // Random items: mostly inserts of fresh or repeated ordinals and reads of
   // buckets in use, with clears now and then.
   task automatic run_random(input int count, input int clear_pct);
      int          r;
      logic [31:0] ord;
      logic [9:0]  idx;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < clear_pct) begin
            send_item(CMD_CLEAR, $urandom, 10'($urandom));
            ord_pool.delete();
         end else if (r < clear_pct + 2)
            send_item(CMD_NONE, $urandom, 10'($urandom));
         else if (r < clear_pct + 27) begin
            idx = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                              : 10'($urandom_range(0, eff_buckets - 1));
            send_item(CMD_READ, $urandom, idx);
         end else begin
            if (ord_pool.size() > 0 && $urandom_range(0, 3) == 0)
               ord = ord_pool[$urandom_range(0, ord_pool.size() - 1)];
            else if ($urandom_range(0, 7) == 0)
               ord = $urandom_range(0, 15);
            else
               ord = $urandom;
            if (ord_pool.size() >= 64) void'(ord_pool.pop_front());
            ord_pool.insert(ord_pool.size(), ord);
            send_item(CMD_INSERT, ord, 10'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset settings.
      send_item(CMD_CLEAR, 32'd0, 10'd0);
      send_item(CMD_INSERT, 32'h0000_0000, 10'd0);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 10'h3FF);
      send_item(CMD_INSERT, 32'hAAAA_AAAA, 10'h2AA);
      send_item(CMD_INSERT, 32'h5555_5555, 10'h155);
      send_item(CMD_INSERT, 32'h0000_0000, 10'd0);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_READ, 32'hFFFF_FFFF, 10'd0);
      send_item(CMD_READ, 32'd0, 10'h3FF);
      send_item(CMD_NONE, 32'hFFFF_FFFF, 10'h3FF);
      send_item(CMD_CLEAR, 32'hFFFF_FFFF, 10'h3FF);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 10'd0);
      drain();

      // Out-of-range registers: smallest table, one candidate, one step.
      set_registers(64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 3'd0, 16'd0);
      send_item(CMD_CLEAR, 32'd0, 10'd0);
      send_item(CMD_INSERT, 32'd1, 10'd0);
      send_item(CMD_INSERT, 32'd2, 10'd0);
      send_item(CMD_INSERT, 32'd3, 10'd0);
      send_item(CMD_INSERT, 32'd4, 10'd0);
      send_item(CMD_READ, 32'd0, 10'd0);
      send_item(CMD_READ, 32'd0, 10'd1);
      run_random(120, 8);
      drain();

      // Saturating upper values, long walk limit, table mostly empty; no random idling.
      gap_max = 0;
      set_registers({$urandom, $urandom}, 11'h7FF, 3'd7, 16'hFFFF);
      run_random(250, 3);
      drain();
      gap_max = 4;

      // Two buckets, four candidates, short walks.
      set_registers({$urandom, $urandom}, 11'd2, 3'd4, 16'd5);
      run_random(100, 12);
      drain();

      // Small table, frequent failures; entries kept across the next change.
      set_registers({$urandom, $urandom}, 11'd16, 3'd2, 16'd6);
      run_random(220, 8);
      drain();

      set_registers({$urandom, $urandom}, 11'd64, 3'd3, 16'd30);
      run_random(300, 3);
      drain();

      // Reset-like settings with a fresh seed and the full table.
      set_registers({$urandom, $urandom}, 11'd1024, 3'd3, 16'd10000);
      run_random(500, 2);
      drain();

      if (fail_count == 0)
         $display("cuckoo_random_walk_placer_unit: match");
      else
         $display("cuckoo_random_walk_placer_unit: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
